>>> sv/cglm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cglm_pkg
// Shared types, constants and helpers of the collision grid line march block.
// ---------------------------------------------------------------------------
package cglm_pkg;

  // grid size limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int GRID_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int XC_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YC_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EFFW_W     = $clog2(MAX_WIDTH + 1);
  localparam int EFFH_W     = $clog2(MAX_HEIGHT + 1);
  localparam int PROD_W     = ADDR_W + EFFW_W;

  // field widths
  localparam int OP_W       = 3;
  localparam int COORD_W    = 16;
  localparam int CELL_W     = 24;
  localparam int DIM_W      = 9;
  localparam int STEP_W     = 16;
  localparam int BUDGET_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // march position: Q32.16, cell coordinate as 33-bit signed
  localparam int LOC_W = 33;
  localparam int POS_W = LOC_W - 1 + 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_POINT = 3'd3;
  localparam logic [OP_W-1:0] OP_LINE  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_BUDGET = 2'd3;

  typedef enum logic [2:0] {
    K_WRITE,
    K_CLEAR,
    K_READ,
    K_POINT,
    K_LINE,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [COORD_W-1:0]  sx;
    logic signed [COORD_W-1:0]  sy;
    logic signed [COORD_W-1:0]  ex;
    logic signed [COORD_W-1:0]  ey;
    logic [CELL_W-1:0]          val;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // effective configuration (clamped, zero step and budget act as one)
  typedef struct packed {
    logic [EFFW_W-1:0]   width;
    logic [EFFH_W-1:0]   height;
    logic [STEP_W-1:0]   step;
    logic [BUDGET_W-1:0] budget;
  } cfg_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } cell_loc_t;

  // bounds check and row-major address of a cell
  function automatic cell_loc_t cell_locate(input logic signed [LOC_W-1:0] x,
                                            input logic signed [LOC_W-1:0] y,
                                            input logic [EFFW_W-1:0] w,
                                            input logic [EFFH_W-1:0] h);
    cell_loc_t          r;
    logic [PROD_W-1:0]  prod;
    r.ok = !x[LOC_W-1] && !y[LOC_W-1] &&
           (x[LOC_W-2:0] < (LOC_W-1)'(w)) && (y[LOC_W-2:0] < (LOC_W-1)'(h));
    prod = PROD_W'(y[YC_W-1:0]) * PROD_W'(w) + PROD_W'(x[XC_W-1:0]);
    r.addr = prod[ADDR_W-1:0];
    return r;
  endfunction

  // widen an input coordinate
  function automatic logic signed [LOC_W-1:0] coord_ext(input logic signed [COORD_W-1:0] c);
    return {{(LOC_W-COORD_W){c[COORD_W-1]}}, c};
  endfunction

endpackage

>>> sv/cglm_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cglm_in_if
// Request channel: operation and coordinates with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface cglm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cglm_pkg::OP_W-1:0]            operation;
  logic signed [cglm_pkg::COORD_W-1:0]  start_x;
  logic signed [cglm_pkg::COORD_W-1:0]  start_y;
  logic signed [cglm_pkg::COORD_W-1:0]  end_x;
  logic signed [cglm_pkg::COORD_W-1:0]  end_y;
  logic [cglm_pkg::CELL_W-1:0]          cell_value;

  modport source(output valid, operation, start_x, start_y, end_x, end_y, cell_value,
                 input ready);
  modport sink(input valid, operation, start_x, start_y, end_x, end_y, cell_value,
               output ready);
endinterface

>>> sv/cglm_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cglm_out_if
// Result channel: blocked flag and read value with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface cglm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         blocked;
  logic [cglm_pkg::CELL_W-1:0]  read_value;

  modport source(output valid, blocked, read_value, input ready);
  modport sink(input valid, blocked, read_value, output ready);
endinterface

>>> sv/cglm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cglm_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module cglm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/cglm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cglm_front
// Accepts requests, classifies the operation and queues them in two slots.
// ---------------------------------------------------------------------------
module cglm_front (
  input  logic                clk,
  input  logic                rst_n,
  cglm_in_if.sink             in_ch,
  output cglm_pkg::cmd_slot_t head,
  input  logic                head_pop
);
  import cglm_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  cmd_t       new_cmd;

  // operation decode
  always_comb begin
    new_cmd.sx  = in_ch.start_x;
    new_cmd.sy  = in_ch.start_y;
    new_cmd.ex  = in_ch.end_x;
    new_cmd.ey  = in_ch.end_y;
    new_cmd.val = in_ch.cell_value;
    case (in_ch.operation)
      OP_WRITE: new_cmd.kind = K_WRITE;
      OP_CLEAR: new_cmd.kind = K_CLEAR;
      OP_READ:  new_cmd.kind = K_READ;
      OP_POINT: new_cmd.kind = K_POINT;
      OP_LINE:  new_cmd.kind = K_LINE;
      default:  new_cmd.kind = K_NOP;
    endcase
  end

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = head_pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = slot_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

>>> sv/cglm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cglm_back
// Executes queued operations: cell access, point test and the line march
// with a bit-serial square root and divider, and holds the result register.
// ---------------------------------------------------------------------------
module cglm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cglm_pkg::cfg_t      cfg,
  input  cglm_pkg::cmd_slot_t head,
  output logic                head_pop,
  cglm_out_if.source          out_ch
);
  import cglm_pkg::*;

  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SREM_W  = ROOT_W + 3;
  localparam int DVD_W   = COORD_W + 31;
  localparam int Q_W     = COORD_W + 2;
  localparam int MAG_W   = Q_W + STEP_W - 8;
  localparam int INC_W   = MAG_W + 1;
  localparam int RX_W    = POS_W + 1 - 8;
  localparam int ROUND_W = 24;
  localparam int CNT_W   = $clog2(DVD_W);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_DISP = 12'b0000_0000_0010,
    ST_RD0  = 12'b0000_0000_0100,
    ST_RD1  = 12'b0000_0000_1000,
    ST_SQ   = 12'b0000_0001_0000,
    ST_SQRT = 12'b0000_0010_0000,
    ST_DIVX = 12'b0000_0100_0000,
    ST_DIVY = 12'b0000_1000_0000,
    ST_INC  = 12'b0001_0000_0000,
    ST_DIST = 12'b0010_0000_0000,
    ST_CMP  = 12'b0100_0000_0000,
    ST_SAMP = 12'b1000_0000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  cmd_t                      cmd_r, cmd_nxt;
  logic                      loaded_r, loaded_nxt;
  logic                      ov_r, ov_nxt;
  logic                      blocked_r, blocked_nxt;
  logic [CELL_W-1:0]         rval_r, rval_nxt;
  logic [COORD_W-1:0]        adx_r, adx_nxt, ady_r, ady_nxt;
  logic                      sgnx_r, sgnx_nxt, sgny_r, sgny_nxt;
  logic [RAD_W-1:0]          sq_op_r, sq_op_nxt;
  logic [SREM_W-1:0]         sq_rem_r, sq_rem_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [DVD_W-1:0]          dv_sh_r, dv_sh_nxt;
  logic [ROOT_W-1:0]         dv_rem_r, dv_rem_nxt;
  logic [Q_W-1:0]            qx_r, qx_nxt;
  logic signed [INC_W-1:0]   incx_r, incx_nxt, incy_r, incy_nxt;
  logic [2*STEP_W-1:0]       st2_r, st2_nxt;
  logic signed [POS_W-1:0]   px_r, px_nxt, py_r, py_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  logic [BUDGET_W-1:0]       budget_r, budget_nxt;
  logic [ROUND_W-1:0]        round_r, round_nxt;
  logic [15:0]               rxm_r, rxm_nxt, rym_r, rym_nxt;
  logic                      far_r, far_nxt;
  cell_loc_t                 loc_r, loc_nxt;

  // ram port
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [CELL_W-1:0]         ram_rdata;

  // combinational helpers
  cell_loc_t                 start_loc, end_loc;
  logic signed [COORD_W:0]   dx, dy;
  logic [2*COORD_W-1:0]      sqx, sqy;
  logic [SQ_W-1:0]           sq_sum;
  logic [SREM_W-1:0]         srem_sh, strial;
  logic [ROOT_W:0]           drem_sh;
  logic [DVD_W-1:0]          dv_sh_step;
  logic [ROOT_W-1:0]         dv_rem_step;
  logic [Q_W+STEP_W-1:0]     prodx, prody;
  logic [MAG_W-1:0]          magx, magy;
  logic signed [POS_W:0]     dfx, dfy;
  logic [POS_W:0]            afx, afy;
  logic [RX_W-1:0]           rx, ry;
  logic [POS_W-1:0]          pax, pay;
  logic [LOC_W-2:0]          cxm, cym;
  logic signed [LOC_W-1:0]   cx, cy;
  logic [31:0]               rsqx, rsqy;
  logic [32:0]               rsum;
  logic                      zero_cell;

  cglm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (start_loc.addr),
    .wdata (cmd_r.val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign start_loc = cell_locate(coord_ext(cmd_r.sx), coord_ext(cmd_r.sy),
                                 cfg.width, cfg.height);
  assign end_loc   = cell_locate(coord_ext(cmd_r.ex), coord_ext(cmd_r.ey),
                                 cfg.width, cfg.height);

  assign head_pop = (state_r == ST_IDLE) && !ov_r && head.valid;

  assign out_ch.valid      = ov_r;
  assign out_ch.blocked    = blocked_r;
  assign out_ch.read_value = rval_r;

  // endpoint delta and squared length
  always_comb begin
    dx     = {cmd_r.ex[COORD_W-1], cmd_r.ex} - {cmd_r.sx[COORD_W-1], cmd_r.sx};
    dy     = {cmd_r.ey[COORD_W-1], cmd_r.ey} - {cmd_r.sy[COORD_W-1], cmd_r.sy};
    sqx    = (2*COORD_W)'(adx_r) * (2*COORD_W)'(adx_r);
    sqy    = (2*COORD_W)'(ady_r) * (2*COORD_W)'(ady_r);
    sq_sum = SQ_W'(sqx) + SQ_W'(sqy);
  end

  // square root step: two radicand bits per cycle
  always_comb begin
    srem_sh = {sq_rem_r[SREM_W-3:0], sq_op_r[RAD_W-1:RAD_W-2]};
    strial  = SREM_W'({root_r, 2'b01});
  end

  // restoring divider step: one quotient bit per cycle
  always_comb begin
    drem_sh = {dv_rem_r, dv_sh_r[DVD_W-1]};
    if (drem_sh >= {1'b0, root_r}) begin
      dv_rem_step = ROOT_W'(drem_sh - {1'b0, root_r});
      dv_sh_step  = {dv_sh_r[DVD_W-2:0], 1'b1};
    end else begin
      dv_rem_step = drem_sh[ROOT_W-1:0];
      dv_sh_step  = {dv_sh_r[DVD_W-2:0], 1'b0};
    end
  end

  // per-step increments
  always_comb begin
    prodx = (Q_W+STEP_W)'(qx_r) * (Q_W+STEP_W)'(cfg.step);
    prody = (Q_W+STEP_W)'(dv_sh_r[Q_W-1:0]) * (Q_W+STEP_W)'(cfg.step);
    magx  = prodx[Q_W+STEP_W-1:8];
    magy  = prody[Q_W+STEP_W-1:8];
  end

  // remaining distance and sample cell
  always_comb begin
    dfx = {tx_r[POS_W-1], tx_r} - {px_r[POS_W-1], px_r};
    dfy = {ty_r[POS_W-1], ty_r} - {py_r[POS_W-1], py_r};
    afx = dfx[POS_W] ? (POS_W+1)'(-dfx) : dfx;
    afy = dfy[POS_W] ? (POS_W+1)'(-dfy) : dfy;
    rx  = afx[POS_W:8];
    ry  = afy[POS_W:8];
    pax = px_r[POS_W-1] ? POS_W'(-px_r) : px_r;
    pay = py_r[POS_W-1] ? POS_W'(-py_r) : py_r;
    cxm = pax[POS_W-1:16];
    cym = pay[POS_W-1:16];
    cx  = (px_r[POS_W-1] && (cxm != '0)) ? '1 : {1'b0, cxm};
    cy  = (py_r[POS_W-1] && (cym != '0)) ? '1 : {1'b0, cym};
    rsqx = 32'(rxm_r) * 32'(rxm_r);
    rsqy = 32'(rym_r) * 32'(rym_r);
    rsum = 33'(rsqx) + 33'(rsqy);
    zero_cell = !loc_r.ok || (ram_rdata == '0);
  end

  // ram read address by state
  always_comb begin
    case (state_r)
      ST_DISP: ram_raddr = (cmd_r.kind == K_LINE) ? end_loc.addr : start_loc.addr;
      ST_RD0:  ram_raddr = start_loc.addr;
      default: ram_raddr = loc_r.addr;
    endcase
  end

  assign ram_we = (state_r == ST_DISP) && (cmd_r.kind == K_WRITE) && start_loc.ok;

  // control and datapath next state
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    loaded_nxt  = loaded_r;
    ov_nxt      = ov_r;
    blocked_nxt = blocked_r;
    rval_nxt    = rval_r;
    adx_nxt     = adx_r;
    ady_nxt     = ady_r;
    sgnx_nxt    = sgnx_r;
    sgny_nxt    = sgny_r;
    sq_op_nxt   = sq_op_r;
    sq_rem_nxt  = sq_rem_r;
    root_nxt    = root_r;
    cnt_nxt     = cnt_r;
    dv_sh_nxt   = dv_sh_r;
    dv_rem_nxt  = dv_rem_r;
    qx_nxt      = qx_r;
    incx_nxt    = incx_r;
    incy_nxt    = incy_r;
    st2_nxt     = st2_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    tx_nxt      = tx_r;
    ty_nxt      = ty_r;
    budget_nxt  = budget_r;
    round_nxt   = round_r;
    rxm_nxt     = rxm_r;
    rym_nxt     = rym_r;
    far_nxt     = far_r;
    loc_nxt     = loc_r;

    // result transfer frees the output register
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (head_pop) begin
          cmd_nxt   = head.cmd;
          state_nxt = ST_DISP;
        end
      end

      ST_DISP: begin
        blocked_nxt = 1'b0;
        rval_nxt    = '0;
        case (cmd_r.kind)
          K_WRITE: begin
            loaded_nxt = 1'b1;
            ov_nxt     = 1'b1;
            state_nxt  = ST_IDLE;
          end
          K_CLEAR: begin
            loaded_nxt = 1'b0;
            ov_nxt     = 1'b1;
            state_nxt  = ST_IDLE;
          end
          K_READ: begin
            if (!loaded_r || !start_loc.ok) begin
              rval_nxt  = CELL_W'(!loaded_r);
              ov_nxt    = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_RD0;
            end
          end
          K_POINT: begin
            if (!loaded_r || !start_loc.ok) begin
              blocked_nxt = loaded_r;
              ov_nxt      = 1'b1;
              state_nxt   = ST_IDLE;
            end else begin
              state_nxt = ST_RD0;
            end
          end
          K_LINE: begin
            if (!loaded_r || !end_loc.ok) begin
              blocked_nxt = loaded_r;
              ov_nxt      = 1'b1;
              state_nxt   = ST_IDLE;
            end else begin
              state_nxt = ST_RD0;
            end
          end
          default: begin
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end

      // first cell read back
      ST_RD0: begin
        if (cmd_r.kind == K_READ) begin
          rval_nxt  = ram_rdata;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cmd_r.kind == K_POINT || ram_rdata[15:0] == '0) begin
          blocked_nxt = (ram_rdata[15:0] == '0);
          ov_nxt      = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (!start_loc.ok) begin
          blocked_nxt = 1'b1;
          ov_nxt      = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_RD1;
        end
      end

      // start cell of a line
      ST_RD1: begin
        if (ram_rdata[15:0] == '0) begin
          blocked_nxt = 1'b1;
          ov_nxt      = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          sgnx_nxt  = dx[COORD_W];
          sgny_nxt  = dy[COORD_W];
          adx_nxt   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
          ady_nxt   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
          state_nxt = ST_SQ;
        end
      end

      ST_SQ: begin
        if (sq_sum == '0) begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          sq_op_nxt  = RAD_W'({sq_sum, 30'b0});
          sq_rem_nxt = '0;
          root_nxt   = '0;
          cnt_nxt    = CNT_W'(ROOT_W - 1);
          state_nxt  = ST_SQRT;
        end
      end

      ST_SQRT: begin
        sq_op_nxt = {sq_op_r[RAD_W-3:0], 2'b00};
        if (srem_sh >= strial) begin
          sq_rem_nxt = srem_sh - strial;
          root_nxt   = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_nxt = srem_sh;
          root_nxt   = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          dv_sh_nxt  = {adx_r, 31'b0};
          dv_rem_nxt = '0;
          cnt_nxt    = CNT_W'(DVD_W - 1);
          state_nxt  = ST_DIVX;
        end
      end

      ST_DIVX: begin
        dv_sh_nxt  = dv_sh_step;
        dv_rem_nxt = dv_rem_step;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          qx_nxt     = dv_sh_step[Q_W-1:0];
          dv_sh_nxt  = {ady_r, 31'b0};
          dv_rem_nxt = '0;
          cnt_nxt    = CNT_W'(DVD_W - 1);
          state_nxt  = ST_DIVY;
        end
      end

      ST_DIVY: begin
        dv_sh_nxt  = dv_sh_step;
        dv_rem_nxt = dv_rem_step;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_INC;
        end
      end

      // march setup
      ST_INC: begin
        incx_nxt   = sgnx_r ? INC_W'(-$signed({1'b0, magx})) : $signed({1'b0, magx});
        incy_nxt   = sgny_r ? INC_W'(-$signed({1'b0, magy})) : $signed({1'b0, magy});
        st2_nxt    = (2*STEP_W)'(cfg.step) * (2*STEP_W)'(cfg.step);
        px_nxt     = {{(POS_W-COORD_W-16){cmd_r.sx[COORD_W-1]}}, cmd_r.sx, 16'b0};
        py_nxt     = {{(POS_W-COORD_W-16){cmd_r.sy[COORD_W-1]}}, cmd_r.sy, 16'b0};
        tx_nxt     = {{(POS_W-COORD_W-16){cmd_r.ex[COORD_W-1]}}, cmd_r.ex, 16'b0};
        ty_nxt     = {{(POS_W-COORD_W-16){cmd_r.ey[COORD_W-1]}}, cmd_r.ey, 16'b0};
        budget_nxt = cfg.budget;
        round_nxt  = '0;
        state_nxt  = ST_DIST;
      end

      ST_DIST: begin
        rxm_nxt   = rx[15:0];
        rym_nxt   = ry[15:0];
        far_nxt   = (rx[RX_W-1:16] != '0) || (ry[RX_W-1:16] != '0);
        loc_nxt   = cell_locate(cx, cy, cfg.width, cfg.height);
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        if (!far_r && rsum <= 33'(st2_r)) begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SAMP;
        end
      end

      ST_SAMP: begin
        if (zero_cell && budget_r == BUDGET_W'(1)) begin
          blocked_nxt = 1'b1;
          ov_nxt      = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          budget_nxt = budget_r - BUDGET_W'(zero_cell);
          px_nxt     = px_r + {{(POS_W-INC_W){incx_r[INC_W-1]}}, incx_r};
          py_nxt     = py_r + {{(POS_W-INC_W){incy_r[INC_W-1]}}, incy_r};
          round_nxt  = round_r + 1'b1;
          if (round_r == '1) begin
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DIST;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      loaded_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    blocked_r <= blocked_nxt;
    rval_r    <= rval_nxt;
    adx_r     <= adx_nxt;
    ady_r     <= ady_nxt;
    sgnx_r    <= sgnx_nxt;
    sgny_r    <= sgny_nxt;
    sq_op_r   <= sq_op_nxt;
    sq_rem_r  <= sq_rem_nxt;
    root_r    <= root_nxt;
    cnt_r     <= cnt_nxt;
    dv_sh_r   <= dv_sh_nxt;
    dv_rem_r  <= dv_rem_nxt;
    qx_r      <= qx_nxt;
    incx_r    <= incx_nxt;
    incy_r    <= incy_nxt;
    st2_r     <= st2_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    tx_r      <= tx_nxt;
    ty_r      <= ty_nxt;
    budget_r  <= budget_nxt;
    round_r   <= round_nxt;
    rxm_r     <= rxm_nxt;
    rym_r     <= rym_nxt;
    far_r     <= far_nxt;
    loc_r     <= loc_nxt;
  end

endmodule

>>> sv/collision_grid_line_march.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// collision_grid_line_march
// Collision grid of 24-bit cells with cell access, point and line tests.
// ---------------------------------------------------------------------------
// A two-slot request queue sits in front of a single execution engine; one
// operation runs at a time and each result waits in an output register.
// Write, clear and unloaded or out-of-grid cases finish in the dispatch state
// once the queue hands the request over, and in-grid reads and point tests
// add a read state, bound by the one registered read port of the grid RAM.
// A line test reads both endpoints, then runs a bit-serial square root and
// two divides for its setup, then takes the distance, compare and sample
// states for each march sample. No clearing pass runs after reset.
module collision_grid_line_march (
  input  logic                                clk,
  input  logic                                rst_n,
  cglm_in_if.sink                             in_ch,
  cglm_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [cglm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cglm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cglm_pkg::*;

  logic [DIM_W-1:0]    map_width_r, map_height_r;
  logic [STEP_W-1:0]   step_size_r;
  logic [BUDGET_W-1:0] hit_budget_r;
  cfg_t                cfg;
  cmd_slot_t           head;
  logic                head_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= '0;
      map_height_r <= '0;
      step_size_r  <= STEP_W'(256);
      hit_budget_r <= BUDGET_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_data[DIM_W-1:0];
        CFG_MAP_HEIGHT: map_height_r <= cfg_data[DIM_W-1:0];
        CFG_STEP_SIZE:  step_size_r  <= cfg_data[STEP_W-1:0];
        CFG_HIT_BUDGET: hit_budget_r <= cfg_data[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // effective settings
  always_comb begin
    cfg.width  = (32'(map_width_r) > MAX_WIDTH) ? EFFW_W'(MAX_WIDTH)
                                                : EFFW_W'(map_width_r);
    cfg.height = (32'(map_height_r) > MAX_HEIGHT) ? EFFH_W'(MAX_HEIGHT)
                                                  : EFFH_W'(map_height_r);
    cfg.step   = (step_size_r == '0) ? STEP_W'(1) : step_size_r;
    cfg.budget = (hit_budget_r == '0) ? BUDGET_W'(1) : hit_budget_r;
  end

  cglm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .head     (head),
    .head_pop (head_pop)
  );

  cglm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .head     (head),
    .head_pop (head_pop),
    .out_ch   (out_ch)
  );

`ifndef ASSERT_OFF
  // a request handed to the engine keeps it busy the next cycle
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> !head_pop)
    else $error("engine took two requests in a row");

  // a transfer into an empty queue shows at its head next cycle
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !head.valid) |=> head.valid)
    else $error("queued request lost");

  // no new request starts while a result waits
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> !head_pop)
    else $error("request started over a pending result");
`endif

endmodule
